>>> rtl/core/abp_pkg.sv
// Shared codes and types for the 2-D box overlap pair finder.
// No dependencies; imported by the scan sequencer and the top level.
`timescale 1ns / 1ps

package abp_pkg;

	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int BODY_W   = 4;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVERTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd2;

	typedef struct packed {
		logic              found;
		logic              done;
		logic [BODY_W-1:0] first;
		logic [BODY_W-1:0] second;
	} scan_res_t;

endpackage

>>> rtl/core/aabb_broadphase_pair_finder_core.sv
// Add, remove: the result word is loaded into the output register from the reply state once that register is free.
// Next pair: for each used first slot the sequencer loads its box, then compares the candidate
// second slots one at a time, through the single overlap compare unit.
// A new word is taken once the previous result is loaded into the output register.
// Reset empties the slot table and rewinds the pair walk; box memory is not cleared.
`timescale 1ns / 1ps

module aabb_broadphase_pair_finder_core import abp_pkg::*; #(
	parameter int MAX_BODIES = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_W-1:0]    mode,
	input  logic [BODY_W-1:0]    body_slot,
	input  logic signed [31:0]   box_min_x,
	input  logic signed [31:0]   box_max_x,
	input  logic signed [31:0]   box_min_y,
	input  logic signed [31:0]   box_max_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic                 pair_found,
	output logic [BODY_W-1:0]    first_body,
	output logic [BODY_W-1:0]    second_body,
	output logic                 scan_done
);

	localparam int IDXW = $clog2(MAX_BODIES);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_REPLY = 2'd2;

	logic [1:0]             state_q;
	logic [MAX_BODIES-1:0]  used_q;
	logic [STATUS_W-1:0]    rep_status_q;
	scan_res_t              rep_res_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	scan_res_t              out_res_q;

	logic                         accept, slot_ok, inverted, out_free;
	logic                         wr_en, rd_en, seq_fin;
	logic [8:0]                   slot_ext;
	logic [IDXW-1:0]              slot_idx, rd_addr;
	logic signed [COORD_BITS-1:0] min_x_c, max_x_c, min_y_c, max_y_c;
	logic [4*COORD_BITS-1:0]      rd_data;
	logic [STATUS_W-1:0]          upd_status;
	scan_res_t                    seq_res;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign slot_ext = {5'd0, body_slot};
	assign slot_ok  = slot_ext < 9'(MAX_BODIES);
	assign slot_idx = IDXW'(body_slot);

	assign min_x_c  = box_min_x[COORD_BITS-1:0];
	assign max_x_c  = box_max_x[COORD_BITS-1:0];
	assign min_y_c  = box_min_y[COORD_BITS-1:0];
	assign max_y_c  = box_max_y[COORD_BITS-1:0];
	assign inverted = (min_x_c > max_x_c) || (min_y_c > max_y_c);

	assign wr_en = accept && (mode == MODE_ADD) && slot_ok && !inverted;

	always_comb begin
		upd_status = STATUS_OK;
		if ((mode == MODE_ADD) || (mode == MODE_REMOVE)) begin
			if (!slot_ok) begin
				upd_status = STATUS_NO_SLOT;
			end else if (mode == MODE_ADD) begin
				upd_status = inverted ? STATUS_INVERTED : STATUS_OK;
			end else begin
				upd_status = used_q[slot_idx] ? STATUS_OK : STATUS_NO_SLOT;
			end
		end
	end

	abp_box_store #(
		.MAX_BODIES(MAX_BODIES),
		.COORD_BITS(COORD_BITS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot_idx),
		.wr_data({min_x_c, max_x_c, min_y_c, max_y_c}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	abp_scan_seq #(
		.MAX_BODIES(MAX_BODIES),
		.COORD_BITS(COORD_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (mode == MODE_NEXT)),
		.restart(accept && ((mode == MODE_ADD) || (mode == MODE_REMOVE))),
		.used   (used_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.fin    (seq_fin),
		.res    (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && slot_ok) begin
				if ((mode == MODE_ADD) && !inverted) begin
					used_q[slot_idx] <= 1'b1;
				end else if (mode == MODE_REMOVE) begin
					used_q[slot_idx] <= 1'b0;
				end
			end
			if ((state_q == S_REPLY) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (mode == MODE_NEXT) ? S_SCAN : S_REPLY;
					end
				end
				S_SCAN: begin
					if (seq_fin) begin
						state_q <= S_REPLY;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rep_status_q <= upd_status;
			rep_res_q    <= '0;
		end else if ((state_q == S_SCAN) && seq_fin) begin
			rep_status_q <= STATUS_OK;
			rep_res_q    <= seq_res;
		end
		if ((state_q == S_REPLY) && out_free) begin
			status_q  <= rep_status_q;
			out_res_q <= rep_res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pair_found  = out_res_q.found;
	assign first_body  = out_res_q.first;
	assign second_body = out_res_q.second;
	assign scan_done   = out_res_q.done;

	a_rise_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_REPLY))
		else $error("result word appeared outside the reply state");

	a_found_xor_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_res_q.found && out_res_q.done))
		else $error("pair and end of scan reported together");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.found) |-> (out_res_q.first < out_res_q.second))
		else $error("pair slots out of order");

	a_status_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != STATUS_OK)) |-> (!out_res_q.found && !out_res_q.done))
		else $error("error status carried scan fields");

endmodule

>>> rtl/core/abp_box_store.sv
// Box table memory: one write port, one registered read port.
// Each entry packs min x, max x, min y and max y; no package dependency.
`timescale 1ns / 1ps

module abp_box_store #(
	parameter int MAX_BODIES = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [$clog2(MAX_BODIES)-1:0]         wr_addr,
	input  logic [4*COORD_BITS-1:0]               wr_data,
	input  logic                                  rd_en,
	input  logic [$clog2(MAX_BODIES)-1:0]         rd_addr,
	output logic [4*COORD_BITS-1:0]               rd_data
);

	logic [4*COORD_BITS-1:0] mem [MAX_BODIES];
	logic [4*COORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/abp_overlap_unit.sv
// Strict overlap test of two boxes on both axes, shared by every pair compare.
// Boxes are packed as {min x, max x, min y, max y}; no package dependency.
`timescale 1ns / 1ps

module abp_overlap_unit #(
	parameter int COORD_BITS = 32
) (
	input  logic [4*COORD_BITS-1:0] box_a,
	input  logic [4*COORD_BITS-1:0] box_b,
	output logic                    meet
);

	logic signed [COORD_BITS-1:0] a_min_x, a_max_x, a_min_y, a_max_y;
	logic signed [COORD_BITS-1:0] b_min_x, b_max_x, b_min_y, b_max_y;

	assign a_min_x = box_a[4*COORD_BITS-1:3*COORD_BITS];
	assign a_max_x = box_a[3*COORD_BITS-1:2*COORD_BITS];
	assign a_min_y = box_a[2*COORD_BITS-1:COORD_BITS];
	assign a_max_y = box_a[COORD_BITS-1:0];
	assign b_min_x = box_b[4*COORD_BITS-1:3*COORD_BITS];
	assign b_max_x = box_b[3*COORD_BITS-1:2*COORD_BITS];
	assign b_min_y = box_b[2*COORD_BITS-1:COORD_BITS];
	assign b_max_y = box_b[COORD_BITS-1:0];

	assign meet = (a_min_x < b_max_x) && (b_min_x < a_max_x) &&
		(a_min_y < b_max_y) && (b_min_y < a_max_y);

endmodule

>>> rtl/core/abp_scan_seq.sv
// Pair walk sequencer: steps the slot pair cursor, reads boxes from the store and,
// while walking second slots, feeds the shared overlap unit once per cycle. Uses abp_pkg and abp_overlap_unit.
`timescale 1ns / 1ps

module abp_scan_seq import abp_pkg::*; #(
	parameter int MAX_BODIES = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          restart,
	input  logic [MAX_BODIES-1:0]         used,
	output logic                          rd_en,
	output logic [$clog2(MAX_BODIES)-1:0] rd_addr,
	input  logic [4*COORD_BITS-1:0]       rd_data,
	output logic                          fin,
	output scan_res_t                     res
);

	localparam int IDXW = $clog2(MAX_BODIES);
	localparam int CNTW = $clog2(MAX_BODIES + 1);
	localparam logic [CNTW-1:0] LAST = CNTW'(MAX_BODIES);

	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_PICK = 2'd1;
	localparam logic [1:0] SQ_LOAD = 2'd2;
	localparam logic [1:0] SQ_WALK = 2'd3;

	logic [1:0]             sq_q;
	logic [CNTW-1:0]        i_q, j_q, scan_first_q, scan_second_q;
	logic                   first_q, cmp_v_q, fin_q;
	logic [IDXW-1:0]        cmp_j_q;
	logic [4*COORD_BITS-1:0] ref_box_q;
	scan_res_t              res_q;

	logic [CNTW-1:0] i_next, j_start;
	logic            i_used, meet, hit;

	assign i_next  = i_q + CNTW'(1);
	assign j_start = (first_q && (scan_second_q > i_next)) ? scan_second_q : i_next;
	assign i_used  = (i_q != LAST) && used[i_q[IDXW-1:0]];
	assign hit     = (sq_q == SQ_WALK) && cmp_v_q && meet;

	abp_overlap_unit #(
		.COORD_BITS(COORD_BITS)
	) u_overlap (
		.box_a(ref_box_q),
		.box_b(rd_data),
		.meet (meet)
	);

	always_comb begin
		rd_en   = ((sq_q == SQ_PICK) && i_used) ||
			((sq_q == SQ_WALK) && !hit && (j_q != LAST));
		rd_addr = (sq_q == SQ_PICK) ? i_q[IDXW-1:0] : j_q[IDXW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q          <= SQ_IDLE;
			i_q           <= '0;
			j_q           <= '0;
			scan_first_q  <= '0;
			scan_second_q <= '0;
			first_q       <= 1'b0;
			cmp_v_q       <= 1'b0;
			fin_q         <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			unique case (sq_q)
				SQ_IDLE: begin
					if (restart) begin
						scan_first_q  <= '0;
						scan_second_q <= '0;
					end else if (start) begin
						i_q     <= scan_first_q;
						first_q <= 1'b1;
						sq_q    <= SQ_PICK;
					end
				end
				SQ_PICK: begin
					if (i_q == LAST) begin
						scan_first_q  <= '0;
						scan_second_q <= '0;
						fin_q         <= 1'b1;
						sq_q          <= SQ_IDLE;
					end else if (!i_used) begin
						i_q     <= i_next;
						first_q <= 1'b0;
					end else begin
						j_q     <= j_start;
						cmp_v_q <= 1'b0;
						sq_q    <= SQ_LOAD;
					end
				end
				SQ_LOAD: begin
					sq_q <= SQ_WALK;
				end
				SQ_WALK: begin
					if (hit) begin
						scan_first_q  <= i_q;
						scan_second_q <= CNTW'(cmp_j_q) + CNTW'(1);
						fin_q         <= 1'b1;
						sq_q          <= SQ_IDLE;
					end else if (j_q != LAST) begin
						cmp_v_q <= used[j_q[IDXW-1:0]];
						cmp_j_q <= j_q[IDXW-1:0];
						j_q     <= j_q + CNTW'(1);
					end else if (cmp_v_q) begin
						cmp_v_q <= 1'b0;
					end else begin
						i_q     <= i_next;
						first_q <= 1'b0;
						sq_q    <= SQ_PICK;
					end
				end
				default: sq_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sq_q == SQ_LOAD) begin
			ref_box_q <= rd_data;
		end
		if (hit) begin
			res_q.found  <= 1'b1;
			res_q.done   <= 1'b0;
			res_q.first  <= BODY_W'(i_q);
			res_q.second <= BODY_W'(cmp_j_q);
		end else if ((sq_q == SQ_PICK) && (i_q == LAST)) begin
			res_q <= '{found: 1'b0, done: 1'b1, first: '0, second: '0};
		end
	end

	assign fin = fin_q;
	assign res = res_q;

endmodule

>>> tb/sv/tb_aabb_broadphase_pair_finder_core.sv
// Self-checking testbench for the 2-D box overlap pair finder core.
// It keeps its own copy of the slot table, walks pairs the same way, and checks every result word.
// Depends on abp_pkg and aabb_broadphase_pair_finder_core.
`timescale 1ns / 1ps

module tb_aabb_broadphase_pair_finder_core;
	import abp_pkg::*;

	localparam int                NUM_SLOTS   = 16;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int                RAND_WORDS  = 700;
	localparam int                STALL_LIMIT = 5000;
	localparam int                TAIL_CYCLES = 250;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [BODY_W-1:0]   first;
		logic [BODY_W-1:0]   second;
		logic                done;
	} pair_result_t;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [BODY_W-1:0]  slot;
		logic signed [31:0] x0;
		logic signed [31:0] x1;
		logic signed [31:0] y0;
		logic signed [31:0] y1;
		bit                 drain;
	} box_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [MODE_W-1:0]   mode = MODE_NEXT;
	logic [BODY_W-1:0]   body_slot = '0;
	logic signed [31:0]  box_min_x = '0;
	logic signed [31:0]  box_max_x = '0;
	logic signed [31:0]  box_min_y = '0;
	logic signed [31:0]  box_max_y = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                pair_found;
	logic [BODY_W-1:0]   first_body;
	logic [BODY_W-1:0]   second_body;
	logic                scan_done;

	box_word_t    word_q[$];
	pair_result_t pair_q[$];
	box_word_t    cur_word;
	int           errors = 0;
	int           words_sent = 0;
	int           results_seen = 0;
	int           quiet_cycles = 0;

	bit                 slot_used[NUM_SLOTS];
	logic signed [31:0] lo_x[NUM_SLOTS];
	logic signed [31:0] hi_x[NUM_SLOTS];
	logic signed [31:0] lo_y[NUM_SLOTS];
	logic signed [31:0] hi_y[NUM_SLOTS];
	int                 walk_first = 0;
	int                 walk_second = 0;

	aabb_broadphase_pair_finder_core #(
		.MAX_BODIES(NUM_SLOTS),
		.COORD_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.body_slot(body_slot),
		.box_min_x(box_min_x),
		.box_max_x(box_max_x),
		.box_min_y(box_min_y),
		.box_max_y(box_max_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.pair_found(pair_found),
		.first_body(first_body),
		.second_body(second_body),
		.scan_done(scan_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit boxes_cross(int a, int b);
		return lo_x[a] < hi_x[b] && lo_x[b] < hi_x[a] && lo_y[a] < hi_y[b] && lo_y[b] < hi_y[a];
	endfunction

	// Applies one word to the local table and returns the result word it should produce.
	function automatic pair_result_t apply_word(box_word_t w);
		pair_result_t r;
		int           i;
		int           j;
		bit           hit;
		r   = '0;
		hit = 1'b0;
		if (w.mode == MODE_ADD || w.mode == MODE_REMOVE) begin
			walk_first  = 0;
			walk_second = 0;
			if (w.mode == MODE_ADD) begin
				if (w.x0 > w.x1 || w.y0 > w.y1) begin
					r.status = STATUS_INVERTED;
				end else begin
					lo_x[w.slot]      = w.x0;
					hi_x[w.slot]      = w.x1;
					lo_y[w.slot]      = w.y0;
					hi_y[w.slot]      = w.y1;
					slot_used[w.slot] = 1'b1;
				end
			end else if (slot_used[w.slot]) begin
				slot_used[w.slot] = 1'b0;
			end else begin
				r.status = STATUS_NO_SLOT;
			end
		end else if (w.mode == MODE_NEXT) begin
			for (i = walk_first; i < NUM_SLOTS && !hit; i++) begin
				if (slot_used[i]) begin
					j = i + 1;
					if (i == walk_first && walk_second > j)
						j = walk_second;
					for (; j < NUM_SLOTS && !hit; j++) begin
						if (slot_used[j] && boxes_cross(i, j)) begin
							hit         = 1'b1;
							r.found     = 1'b1;
							r.first     = i[BODY_W-1:0];
							r.second    = j[BODY_W-1:0];
							walk_first  = i;
							walk_second = j + 1;
						end
					end
				end
			end
			if (!hit) begin
				r.done      = 1'b1;
				walk_first  = 0;
				walk_second = 0;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pair_q.push_back(apply_word(cur_word));
				words_sent++;
			end
			if (!in_valid || in_ready) begin
				if (word_q.size() > 0 && !(word_q[0].drain && pair_q.size() > 0) &&
						$urandom_range(0, 99) >= ((words_sent >= 300 && words_sent < 430) ? 0 : 28)) begin
					cur_word  = word_q.pop_front();
					in_valid  <= 1'b1;
					mode      <= cur_word.mode;
					body_slot <= cur_word.slot;
					box_min_x <= cur_word.x0;
					box_max_x <= cur_word.x1;
					box_min_y <= cur_word.y0;
					box_max_y <= cur_word.y1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		pair_result_t got;
		pair_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				got = {status, pair_found, first_body, second_body, scan_done};
				if (pair_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word status=%0d found=%0d first=%0d second=%0d done=%0d",
						$time, got.status, got.found, got.first, got.second, got.done);
				end else begin
					want = pair_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected status=%0d found=%0d first=%0d second=%0d done=%0d, actual status=%0d found=%0d first=%0d second=%0d done=%0d",
							$time, want.status, want.found, want.first, want.second, want.done,
							got.status, got.found, got.first, got.second, got.done);
					end
				end
			end
			out_ready <= $urandom_range(0, 99) >= ((results_seen >= 480 && results_seen < 610) ? 0 : 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic queue_word(input logic [MODE_W-1:0] m, input int slot, input logic signed [31:0] x0,
			input logic signed [31:0] x1, input logic signed [31:0] y0, input logic signed [31:0] y1,
			input bit drain);
		box_word_t w;
		w.mode  = m;
		w.slot  = slot[BODY_W-1:0];
		w.x0    = x0;
		w.x1    = x1;
		w.y0    = y0;
		w.y1    = y1;
		w.drain = drain;
		word_q.push_back(w);
	endtask

	task automatic queue_next(input bit drain);
		queue_word(MODE_NEXT, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom, drain);
	endtask

	task automatic queue_remove(input int slot);
		queue_word(MODE_REMOVE, slot, $urandom, $urandom, $urandom, $urandom, 1'b0);
	endtask

	// Boxes on a half-unit grid near the origin, so overlaps and touching edges are common; some are inverted on one axis.
	task automatic queue_local_box(input int slot);
		int x0;
		int x1;
		int y0;
		int y1;
		x0 = (int'($urandom_range(0, 32)) - 16) * 32768;
		x1 = x0 + int'($urandom_range(0, 12)) * 32768;
		y0 = (int'($urandom_range(0, 32)) - 16) * 32768;
		y1 = y0 + int'($urandom_range(0, 12)) * 32768;
		if ($urandom_range(0, 24) == 0)
			queue_word(MODE_ADD, slot, x1 + 1, x0, y0, y1, 1'b0);
		else if ($urandom_range(0, 24) == 0)
			queue_word(MODE_ADD, slot, x0, x1, y1 + 1, y0, 1'b0);
		else
			queue_word(MODE_ADD, slot, x0, x1, y0, y1, 1'b0);
	endtask

	initial begin
		int made;
		int n;
		int pick;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;

		queue_word(MODE_ADD, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
		queue_word(MODE_ADD, 15, 0, 32'sh10000, 0, 32'sh10000, 1'b0);
		queue_next(1'b0);
		queue_next(1'b0);
		queue_word(MODE_ADD, 5, 32'sh10000, 32'sh20000, 32'sh10000, 32'sh20000, 1'b0);
		queue_word(MODE_ADD, 7, 32'sh20000, 32'sh10000, 0, 32'sh10000, 1'b0);
		queue_word(MODE_ADD, 7, 0, 32'sh10000, 32'sh7fffffff, 32'sh80000000, 1'b0);
		queue_word(MODE_ADD, 7, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 1'b0);
		repeat (5) queue_next(1'b0);
		queue_remove(5);
		queue_remove(5);
		queue_word(MODE_UNUSED, 10, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
		queue_word(MODE_ADD, 15, -32'sh10000, -1, -32'sh10000, -1, 1'b0);
		queue_next(1'b0);
		queue_word(MODE_ADD, 10, 32'sh7fffffff, 32'sh7fffffff, -32'sh20000, 0, 1'b0);
		queue_next(1'b0);
		queue_next(1'b1);
		queue_next(1'b0);
		queue_remove(0);
		queue_remove(15);
		queue_remove(7);
		queue_remove(10);

		made = 0;
		while (made < RAND_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				n = $urandom_range(1, 5);
				repeat (n) queue_local_box($urandom_range(0, 15));
				made += n;
				if ($urandom_range(0, 3) == 0) begin
					queue_remove($urandom_range(0, 15));
					made++;
				end
				n = $urandom_range(1, 10);
				repeat (n) queue_next($urandom_range(0, 49) == 0);
				made += n;
			end else if (pick < 70) begin
				a = $urandom;
				b = $urandom;
				c = $urandom;
				d = $urandom;
				if ($urandom_range(0, 3) != 0) begin
					if (a > b) {a, b} = {b, a};
					if (c > d) {c, d} = {d, c};
				end
				queue_word(MODE_ADD, $urandom_range(0, 15), a, b, c, d, 1'b0);
				made++;
			end else if (pick < 82) begin
				queue_remove($urandom_range(0, 15));
				made++;
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) queue_next(1'b0);
				made += n;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() > 0 || in_valid) @(posedge clk);
		while (pair_q.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pair_q.size() > 0)
			$display("%0t: %0d expected words never arrived", $time, pair_q.size());
		if (errors == 0 && pair_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
